FILE: hdl/spq_pkg.sv
// Shared types, constants and sizes for the scale pitch quantizer.
package spq_pkg;

    localparam int VOICES       = 8;
    localparam int TABLE_DEPTH  = 128;
    localparam int PULSE_LENGTH = 512;
    localparam int QUEUE_DEPTH  = 2;

    localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int TIDX_W  = $clog2(TABLE_DEPTH);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int VOICE_W = 3;
    localparam int CV_W    = 16;
    localparam int INDEX_W = 7;
    localparam int NOTE_W  = 20;
    localparam int OFFS_W  = 7;
    localparam int PULSE_W = 10;

    localparam logic [0:0] OP_SAMPLE = 1'b0;
    localparam logic [0:0] OP_WRITE  = 1'b1;

    localparam logic [0:0] REG_NOTE_OFFSET = 1'b0;
    localparam logic [0:0] REG_USE_TRIGGER = 1'b1;

    localparam logic signed [NOTE_W-1:0] SEARCH_BIAS = 20'sd16384;
    localparam logic signed [CV_W-1:0]   HALF_FIX    = 16'sd2048;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_WRITE,
        CMD_DROP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [VOICE_W-1:0]         voice;
        logic signed [CV_W-1:0]     pitch;
        logic signed [CV_W-1:0]     trig;
        logic signed [CV_W-1:0]     transpose;
        logic [TIDX_W-1:0]          index;
        logic signed [NOTE_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic signed [OFFS_W-1:0]   note_offset;
        logic                       use_trigger;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } back_state_t;

endpackage

FILE: hdl/scale_pitch_quantizer.sv
// Scale pitch quantizer: a sample beat is resolved by a linear scan of the note table
// through its single read port, which stops at the first entry above pitch plus 4 V or
// at the last entry; a table write beat is written straight from the queue head. A
// two-deep command queue lets input beats arrive while a sample is scanned, and
// the result register lets the next command start while a result waits. The note table
// has no reset and must be loaded completely before any sample beat is sent.
module scale_pitch_quantizer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    // voice[2:0], pitch_in[18:3], trigger_in[34:19], transpose_in[50:35],
    // entry_index[57:51], entry_value[77:58], zero[79:78]
    input  logic [79:0]     s_tdata,
    // opcode[0]
    input  logic [0:0]      s_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    // pitch_out[19:0], voice_out[22:20], zero[23]
    output logic [23:0]     m_tdata,
    // gate_out[0]
    output logic [0:0]      m_tuser,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    spq_pkg::cfg_t  cfg_reg;
    spq_pkg::cmd_t  push_cmd, head_cmd;
    logic           q_full, q_push, q_pop, q_not_empty;
    logic           cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (paddr[2])
                spq_pkg::REG_NOTE_OFFSET: cfg_reg.note_offset <= pwdata[6:0];
                spq_pkg::REG_USE_TRIGGER: cfg_reg.use_trigger <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            spq_pkg::REG_NOTE_OFFSET: prdata = 32'(cfg_reg.note_offset);
            spq_pkg::REG_USE_TRIGGER: prdata = {31'd0, cfg_reg.use_trigger};
            default:                  prdata = '0;
        endcase
    end

    spq_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    spq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    spq_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (head_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

FILE: hdl/spq_front.sv
// Input side: unpack beats, classify them into commands and push them to the queue.
module spq_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [79:0]                 s_tdata,
    input  logic [0:0]                  s_tuser,
    input  logic                        q_full,
    output logic                        q_push,
    output spq_pkg::cmd_t               q_cmd
);

    logic [spq_pkg::VOICE_W-1:0] voice;
    logic [spq_pkg::INDEX_W-1:0] entry_index;

    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && !q_full;
    assign voice       = s_tdata[2:0];
    assign entry_index = s_tdata[57:51];

    always_comb begin
        q_cmd.voice     = voice;
        q_cmd.pitch     = s_tdata[18:3];
        q_cmd.trig      = s_tdata[34:19];
        q_cmd.transpose = s_tdata[50:35];
        q_cmd.index     = spq_pkg::TIDX_W'(entry_index);
        q_cmd.value     = s_tdata[77:58];
        if (s_tuser == spq_pkg::OP_WRITE) begin
            q_cmd.kind = (32'(entry_index) < spq_pkg::TABLE_DEPTH) ?
                         spq_pkg::CMD_WRITE : spq_pkg::CMD_DROP;
        end else begin
            q_cmd.kind = (32'(voice) < spq_pkg::VOICES) ?
                         spq_pkg::CMD_SAMPLE : spq_pkg::CMD_DROP;
        end
    end

endmodule

FILE: hdl/spq_queue.sv
// Short command queue between the front and back parts.
module spq_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  spq_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output spq_pkg::cmd_t   head_cmd
);

    spq_pkg::cmd_t                 slot_reg [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [spq_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [spq_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    assign full      = (count_reg == spq_pkg::QCNT_W'(spq_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == spq_pkg::QUEUE_DEPTH - 1) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == spq_pkg::QUEUE_DEPTH - 1) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/spq_back.sv
// Execution side: note table, linear search, per-voice hold and gate, output scaling.
module spq_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  spq_pkg::cfg_t       cfg,
    input  logic                q_not_empty,
    input  spq_pkg::cmd_t       q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic [0:0]          m_tuser
);

    logic signed [spq_pkg::NOTE_W-1:0]  table_mem [spq_pkg::TABLE_DEPTH];
    logic signed [spq_pkg::NOTE_W-1:0]  rdata_reg;
    logic [spq_pkg::TIDX_W-1:0]         rd_addr;
    logic                               mem_we;

    spq_pkg::back_state_t               state_reg, state_next;
    logic [spq_pkg::TIDX_W-1:0]         dat_idx_reg, dat_idx_next;
    logic signed [spq_pkg::NOTE_W-1:0]  prev_reg, prev_next;
    logic signed [spq_pkg::NOTE_W-1:0]  cand_reg, cand_next;
    logic signed [16:0]                 limit_reg;
    logic signed [8:0]                  sum_reg;
    logic signed [16:0]                 adj_reg;
    logic [spq_pkg::VOICE_W-1:0]        voice_reg;
    logic signed [spq_pkg::CV_W-1:0]    trig_reg;
    logic                               load_cmd;

    logic signed [spq_pkg::NOTE_W-1:0]  held_reg  [spq_pkg::VOICES];
    logic [spq_pkg::PULSE_W-1:0]        pulse_reg [spq_pkg::VOICES];
    logic                               th_reg    [spq_pkg::VOICES];
    logic [spq_pkg::VIDX_W-1:0]         vidx;
    logic                               upd;
    logic signed [spq_pkg::NOTE_W-1:0]  held_new;
    logic [spq_pkg::PULSE_W-1:0]        pulse_new, pulse_mid;
    logic                               th_new, gate;

    logic signed [19:0]                 tprod, tprod_adj;
    logic signed [7:0]                  semis;
    logic                               sum_neg;
    logic [7:0]                         sum_mag;
    logic [16:0]                        adj_mag;
    logic [16:0]                        third;
    logic signed [21:0]                 res_wide;
    logic signed [spq_pkg::NOTE_W-1:0]  res;

    logic                               out_valid_reg;
    logic signed [spq_pkg::NOTE_W-1:0]  out_pitch_reg;
    logic [spq_pkg::VOICE_W-1:0]        out_voice_reg;
    logic                               out_gate_reg;
    logic                               out_free;

    assign vidx     = spq_pkg::VIDX_W'(voice_reg);
    assign out_free = !out_valid_reg || m_tready;

    // transpose to semitones, truncated toward zero
    assign tprod     = (20'(q_head.transpose) <<< 3) + (20'(q_head.transpose) <<< 2);
    assign tprod_adj = tprod[19] ? tprod + 20'sd4095 : tprod;
    assign semis     = 8'(tprod_adj >>> 12);

    // round(sum * 1024 / 3) = 341*m + (m+1)/3 on the magnitude
    assign sum_neg = sum_reg[8];
    assign sum_mag = sum_neg ? 8'(-sum_reg) : 8'(sum_reg);
    assign third   = 17'(((17'(sum_mag) + 17'd1) * 17'd171) >> 9);
    assign adj_mag = 17'(17'(sum_mag) * 17'd341) + third;

    always_comb begin
        state_next   = state_reg;
        dat_idx_next = dat_idx_reg;
        prev_next    = prev_reg;
        cand_next    = cand_reg;
        rd_addr      = '0;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        load_cmd     = 1'b0;
        upd          = 1'b0;
        case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        spq_pkg::CMD_WRITE: begin
                            mem_we = 1'b1;
                        end
                        spq_pkg::CMD_SAMPLE: begin
                            load_cmd     = 1'b1;
                            dat_idx_next = '0;
                            state_next   = spq_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            spq_pkg::ST_SCAN: begin
                rd_addr      = dat_idx_reg + 1'b1;
                dat_idx_next = dat_idx_reg + 1'b1;
                prev_next    = rdata_reg;
                if (dat_idx_reg != '0) begin
                    if (rdata_reg > limit_reg) begin
                        cand_next  = prev_reg;
                        state_next = spq_pkg::ST_UPDATE;
                    end else if (dat_idx_reg ==
                                 spq_pkg::TIDX_W'(spq_pkg::TABLE_DEPTH - 1)) begin
                        cand_next  = rdata_reg;
                        state_next = spq_pkg::ST_UPDATE;
                    end
                end
            end
            spq_pkg::ST_UPDATE: begin
                if (out_free) begin
                    upd        = 1'b1;
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        held_new  = held_reg[vidx];
        th_new    = th_reg[vidx];
        pulse_mid = pulse_reg[vidx];
        if (!cfg.use_trigger) begin
            if (cand_reg != held_reg[vidx]) begin
                held_new  = cand_reg;
                pulse_new = spq_pkg::PULSE_W'(spq_pkg::PULSE_LENGTH);
                gate      = 1'b1;
            end else if (pulse_mid != '0) begin
                pulse_new = pulse_mid - 1'b1;
                gate      = 1'b1;
            end else begin
                pulse_new = pulse_mid;
                gate      = 1'b0;
            end
        end else begin
            if (!th_reg[vidx] && trig_reg > spq_pkg::HALF_FIX) begin
                th_new    = 1'b1;
                held_new  = cand_reg;
                pulse_mid = spq_pkg::PULSE_W'(spq_pkg::PULSE_LENGTH);
            end else if (th_reg[vidx] && trig_reg < spq_pkg::HALF_FIX) begin
                th_new = 1'b0;
            end
            if (pulse_mid != '0) begin
                pulse_new = pulse_mid - 1'b1;
                gate      = 1'b1;
            end else begin
                pulse_new = pulse_mid;
                gate      = 1'b0;
            end
        end
    end

    assign res_wide = 22'(held_new) - 22'(spq_pkg::SEARCH_BIAS) + 22'(adj_reg);
    always_comb begin
        if (res_wide > 22'sd524287) begin
            res = 20'sh7FFFF;
        end else if (res_wide < -22'sd524288) begin
            res = 20'sh80000;
        end else begin
            res = 20'(res_wide);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[q_head.index] <= q_head.value;
        end
        rdata_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= spq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int v = 0; v < spq_pkg::VOICES; v++) begin
                held_reg[v]  <= '0;
                pulse_reg[v] <= '0;
                th_reg[v]    <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            if (upd) begin
                held_reg[vidx]  <= held_new;
                pulse_reg[vidx] <= pulse_new;
                th_reg[vidx]    <= th_new;
                out_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dat_idx_reg <= dat_idx_next;
        prev_reg    <= prev_next;
        cand_reg    <= cand_next;
        adj_reg     <= sum_neg ? -$signed(adj_mag) : $signed(adj_mag);
        if (load_cmd) begin
            voice_reg <= q_head.voice;
            trig_reg  <= q_head.trig;
            limit_reg <= 17'(q_head.pitch) + 17'sd16384;
            sum_reg   <= 9'(semis) + 9'(cfg.note_offset);
        end
        if (upd) begin
            out_pitch_reg <= res;
            out_voice_reg <= voice_reg;
            out_gate_reg  <= gate;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_voice_reg, out_pitch_reg};
    assign m_tuser  = out_gate_reg;

endmodule

FILE: hdl/spq_checker.sv
// Port-level checks for the scale pitch quantizer, bound to the top level.
module spq_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  logic [79:0]     s_tdata,
    input  logic [0:0]      s_tuser,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [23:0]     m_tdata,
    input  logic [0:0]      m_tuser,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    input  logic [31:0]     prdata,
    input  logic            pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset left a result pending or the queue full");

    a_trigger_read: assert property (@(posedge aclk) disable iff (!aresetn)
        paddr[2] |-> prdata[31:1] == 31'd0 && pready)
        else $error("mode register read returned stray bits");

endmodule

bind scale_pitch_quantizer spq_checker u_spq_checker (.*);
